/* design/reader_writer_lock_manager_core_assert.svh */
// Assertion macros for the reader/writer lock manager checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef READER_WRITER_LOCK_MANAGER_CORE_ASSERT_SVH
`define READER_WRITER_LOCK_MANAGER_CORE_ASSERT_SVH

// Same-cycle implication, reset-gated.
`define RWL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, reset-gated.
`define RWL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

/* design/rwl_pkg.sv */
// Types and constants shared by the reader/writer lock manager.
// No dependencies.
package rwl_pkg;

	localparam int MODE_W = 3;
	localparam int TID_W  = 4;
	localparam int CNT_W  = 5;
	localparam int WCNT_W = 6;
	localparam int ON_W   = 2;

	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
	localparam logic [WCNT_W-1:0] WCNT_MAX  = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_BEGIN_READ  = 3'd0,
		MODE_END_READ    = 3'd1,
		MODE_BEGIN_WRITE = 3'd2,
		MODE_END_WRITE   = 3'd3,
		MODE_TRY_WRITE   = 3'd4
	} rwl_mode_t;

	localparam logic [ON_W-1:0] WAIT_EVEN  = 2'd0;
	localparam logic [ON_W-1:0] WAIT_ODD   = 2'd1;
	localparam logic [ON_W-1:0] WAIT_WRITE = 2'd2;

	typedef struct packed {
		logic              writer_active;
		logic [CNT_W-1:0]  writers_queued;
		logic [CNT_W-1:0]  readers_queued;
		logic [CNT_W-1:0]  readers_active;
		logic              odd_phase;
		logic              owner_valid;
		logic [TID_W-1:0]  owner_thread;
	} rwl_state_t;

	typedef struct packed {
		logic              must_wait;
		logic [ON_W-1:0]   wait_on;
		logic              wake_even_readers;
		logic              wake_odd_readers;
		logic              wake_writer;
		logic              clear_even_readers;
		logic              clear_odd_readers;
		logic              success;
		logic [WCNT_W-1:0] waiting_count;
		logic              error;
	} rwl_rsp_t;

endpackage

/* design/rwl_req_if.sv */
// Request channel: valid/ready with mode and thread id.
// Depends on rwl_pkg for field widths.
interface rwl_req_if;
	logic                       valid;
	logic                       ready;
	logic [rwl_pkg::MODE_W-1:0] mode;
	logic [rwl_pkg::TID_W-1:0]  thread_id;

	modport source(output valid, output mode, output thread_id, input ready);
	modport sink(input valid, input mode, input thread_id, output ready);
endinterface

/* design/rwl_rsp_if.sv */
// Result channel: valid/ready with the per-request outcome fields.
// Depends on rwl_pkg for field widths.
interface rwl_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       must_wait;
	logic [rwl_pkg::ON_W-1:0]   wait_on;
	logic                       wake_even_readers;
	logic                       wake_odd_readers;
	logic                       wake_writer;
	logic                       clear_even_readers;
	logic                       clear_odd_readers;
	logic                       success;
	logic [rwl_pkg::WCNT_W-1:0] waiting_count;
	logic                       error;

	modport source(output valid, output must_wait, output wait_on, output wake_even_readers,
		output wake_odd_readers, output wake_writer, output clear_even_readers,
		output clear_odd_readers, output success, output waiting_count, output error,
		input ready);
	modport sink(input valid, input must_wait, input wait_on, input wake_even_readers,
		input wake_odd_readers, input wake_writer, input clear_even_readers,
		input clear_odd_readers, input success, input waiting_count, input error,
		output ready);
endinterface

/* design/rwl_step.sv */
// Next-state and result logic for one lock request (purely combinational).
// Depends on rwl_pkg.
module rwl_step #(
	parameter int DEPTH_BITS = 8
) (
	input  logic [rwl_pkg::MODE_W-1:0] mode,
	input  logic [rwl_pkg::TID_W-1:0]  thread_id,
	input  logic                       tid_ok,
	input  rwl_pkg::rwl_state_t        st,
	input  logic [DEPTH_BITS-1:0]      owner_depth,
	input  logic [DEPTH_BITS-1:0]      rd_depth,
	output rwl_pkg::rwl_state_t        st_nxt,
	output logic [DEPTH_BITS-1:0]      owner_depth_nxt,
	output logic [DEPTH_BITS-1:0]      rd_depth_nxt,
	output logic                       rd_we,
	output rwl_pkg::rwl_rsp_t          rsp
);
	import rwl_pkg::*;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
	localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);
	localparam logic [CNT_W-1:0]      CNT_ONE   = CNT_W'(1);

	rwl_state_t            nx;
	logic [DEPTH_BITS-1:0] od_n;
	logic [DEPTH_BITS-1:0] dn;
	logic                  we;
	logic                  err;
	logic                  is_owner;
	logic                  down;
	rwl_rsp_t              r;
	logic [WCNT_W:0]       wsum;

	assign is_owner = st.owner_valid && (st.owner_thread == thread_id);
	assign down     = (rd_depth != '0);

	always_comb begin
		nx   = st;
		od_n = owner_depth;
		dn   = rd_depth;
		we   = 1'b0;
		err  = 1'b0;
		r    = '0;
		r.success = 1'b1;

		if (!tid_ok) begin
			err = 1'b1;
		end else begin
			case (mode)
				MODE_BEGIN_READ: begin
					if (rd_depth == DEPTH_MAX) begin
						err = 1'b1;
					end else begin
						if (!is_owner && !down) begin
							if (st.writer_active) begin
								if (st.readers_active == COUNT_MAX) err = 1'b1;
								nx.readers_active = st.readers_active + CNT_ONE;
								r.must_wait = 1'b1;
								r.wait_on = st.odd_phase ? WAIT_ODD : WAIT_EVEN;
							end else if (st.writers_queued != '0) begin
								if (st.readers_queued == COUNT_MAX) err = 1'b1;
								nx.readers_queued = st.readers_queued + CNT_ONE;
								r.must_wait = 1'b1;
								r.wait_on = st.odd_phase ? WAIT_ODD : WAIT_EVEN;
							end else begin
								if (st.readers_active == COUNT_MAX) err = 1'b1;
								nx.readers_active = st.readers_active + CNT_ONE;
							end
						end
						dn = rd_depth + DEPTH_ONE;
						we = 1'b1;
					end
				end
				MODE_END_READ: begin
					if (!down) begin
						err = 1'b1;
					end else begin
						dn = rd_depth - DEPTH_ONE;
						we = 1'b1;
						if ((rd_depth == DEPTH_ONE) && !is_owner) begin
							if ((st.readers_active == CNT_ONE) && (st.writers_queued != '0)) begin
								nx.writers_queued = st.writers_queued - CNT_ONE;
								nx.writer_active  = 1'b1;
								nx.readers_active = st.readers_queued;
								nx.readers_queued = '0;
								r.wake_writer = 1'b1;
							end else if (st.readers_active != '0) begin
								nx.readers_active = st.readers_active - CNT_ONE;
							end
						end
					end
				end
				MODE_BEGIN_WRITE: begin
					if (is_owner) begin
						if (owner_depth == DEPTH_MAX) err = 1'b1;
						od_n = owner_depth + DEPTH_ONE;
					end else if (down) begin
						if (st.readers_active > CNT_ONE) begin
							if (st.writers_queued == COUNT_MAX) err = 1'b1;
							nx.writers_queued = st.writers_queued + CNT_ONE;
							nx.readers_active = st.readers_active - CNT_ONE;
							r.must_wait = 1'b1;
							r.wait_on = WAIT_WRITE;
						end else if (st.writers_queued != '0) begin
							// at most one active reader here: it is the requester
							nx.writer_active  = 1'b1;
							nx.readers_active = st.readers_queued;
							nx.readers_queued = '0;
							r.wake_writer = 1'b1;
							r.must_wait = 1'b1;
							r.wait_on = WAIT_WRITE;
						end else begin
							if (st.readers_active != '0)
								nx.readers_active = st.readers_active - CNT_ONE;
							nx.writer_active = 1'b1;
							nx.owner_valid   = 1'b1;
							nx.owner_thread  = thread_id;
							od_n = DEPTH_ONE;
						end
					end else if (st.writer_active || (st.readers_active != '0)
							|| (st.writers_queued != '0)) begin
						if (st.writers_queued == COUNT_MAX) err = 1'b1;
						nx.writers_queued = st.writers_queued + CNT_ONE;
						r.must_wait = 1'b1;
						r.wait_on = WAIT_WRITE;
					end else begin
						nx.writer_active = 1'b1;
						nx.owner_valid   = 1'b1;
						nx.owner_thread  = thread_id;
						od_n = DEPTH_ONE;
					end
				end
				MODE_END_WRITE: begin
					if (st.owner_valid && (st.owner_thread != thread_id)) begin
						err = 1'b1;
					end else if (st.owner_valid && (owner_depth > DEPTH_ONE)) begin
						od_n = owner_depth - DEPTH_ONE;
						r.success = 1'b0;
					end else if (!st.owner_valid && !st.writer_active) begin
						err = 1'b1;
					end else if (down && (st.readers_active == COUNT_MAX)) begin
						err = 1'b1;
					end else begin
						// full release; flip the read-release phase
						nx.owner_valid  = 1'b0;
						nx.owner_thread = '0;
						od_n = '0;
						r.clear_even_readers = st.odd_phase;
						r.clear_odd_readers  = !st.odd_phase;
						nx.odd_phase = !st.odd_phase;
						if (down || (st.readers_active != '0)) begin
							if (down) nx.readers_active = st.readers_active + CNT_ONE;
							nx.writer_active = 1'b0;
							r.wake_odd_readers  = st.odd_phase;
							r.wake_even_readers = !st.odd_phase;
						end else if (st.writers_queued != '0) begin
							nx.writers_queued = st.writers_queued - CNT_ONE;
							r.wake_writer = 1'b1;
						end else begin
							nx.writer_active = 1'b0;
						end
					end
				end
				MODE_TRY_WRITE: begin
					if (is_owner) begin
						if (owner_depth == DEPTH_MAX) err = 1'b1;
						od_n = owner_depth + DEPTH_ONE;
					end else if (down) begin
						if ((st.readers_active > CNT_ONE) || (st.writers_queued != '0)) begin
							r.success = 1'b0;
						end else begin
							if (st.readers_active != '0)
								nx.readers_active = st.readers_active - CNT_ONE;
							nx.writer_active = 1'b1;
							nx.owner_valid   = 1'b1;
							nx.owner_thread  = thread_id;
							od_n = DEPTH_ONE;
						end
					end else if (st.writer_active || (st.readers_active != '0)
							|| (st.writers_queued != '0)) begin
						r.success = 1'b0;
					end else begin
						nx.writer_active = 1'b1;
						nx.owner_valid   = 1'b1;
						nx.owner_thread  = thread_id;
						od_n = DEPTH_ONE;
					end
				end
				default: err = 1'b1;
			endcase
		end

		if (err) begin
			nx   = st;
			od_n = owner_depth;
			dn   = rd_depth;
			we   = 1'b0;
			r    = '0;
			r.error = 1'b1;
		end

		wsum = (WCNT_W+1)'(nx.readers_queued) + (WCNT_W+1)'(nx.writers_queued)
			+ (nx.writer_active ? (WCNT_W+1)'(nx.readers_active) : '0);
		r.waiting_count = wsum[WCNT_W] ? WCNT_MAX : wsum[WCNT_W-1:0];
	end

	assign st_nxt          = nx;
	assign owner_depth_nxt = od_n;
	assign rd_depth_nxt    = dn;
	assign rd_we           = we;
	assign rsp             = r;
endmodule

/* design/reader_writer_lock_manager_core.sv */
// Reader/writer lock manager with writer preference: top level.
// Depends on rwl_pkg, rwl_req_if, rwl_rsp_if and rwl_step.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    mode, thread_id
//   rsp      out  valid/ready    must_wait, wait_on, wake/clear flags, success,
//                                waiting_count, error
//
// One request per cycle sustained while results are taken; a result is presented
// from the result register after its transfer (request register, then result
// register). The per-thread read depth table and the lock counters are read
// and updated between those registers, so
// back-to-back requests see each other's effects.
// Reset (arst_n low) clears counters, owner, phase and every read depth.
// A stalled result holds in the result register; the request stage moves
// into it as soon as it is free or being taken.
module reader_writer_lock_manager_core #(
	parameter int THREADS    = 16,
	parameter int DEPTH_BITS = 8
) (
	input logic       clk,
	input logic       arst_n,
	rwl_req_if.sink   req,
	rwl_rsp_if.source rsp
);
	import rwl_pkg::*;

	// Only ids the thread_id field can name need a depth entry.
	localparam int ID_SPAN = 1 << TID_W;
	localparam int ENTRIES = (THREADS < ID_SPAN) ? THREADS : ID_SPAN;
	localparam int IDX_W   = $clog2(ENTRIES);

	// request stage
	logic              valid_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [TID_W-1:0]  tid_s1;

	// result register
	logic     rsp_valid_q;
	rwl_rsp_t rsp_q;

	// lock state
	rwl_state_t            st_q;
	logic [DEPTH_BITS-1:0] owner_depth_q;
	logic [DEPTH_BITS-1:0] rd_depth_q [ENTRIES];

	rwl_state_t            st_nxt;
	logic [DEPTH_BITS-1:0] owner_depth_nxt;
	logic [DEPTH_BITS-1:0] rd_depth_nxt;
	logic [DEPTH_BITS-1:0] rd_depth;
	logic                  rd_we;
	logic                  tid_ok;
	logic [IDX_W-1:0]      idx;
	rwl_rsp_t              rsp_nxt;
	logic                  adv;

	// request stage retires when the result register is free or draining
	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	assign tid_ok   = (32'(tid_s1) < THREADS);
	assign idx      = tid_s1[IDX_W-1:0];
	assign rd_depth = tid_ok ? rd_depth_q[idx] : '0;

	rwl_step #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_step (
		.mode           (mode_s1),
		.thread_id      (tid_s1),
		.tid_ok         (tid_ok),
		.st             (st_q),
		.owner_depth    (owner_depth_q),
		.rd_depth       (rd_depth),
		.st_nxt         (st_nxt),
		.owner_depth_nxt(owner_depth_nxt),
		.rd_depth_nxt   (rd_depth_nxt),
		.rd_we          (rd_we),
		.rsp            (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1 <= req.mode;
			tid_s1  <= req.thread_id;
		end
	end

	// lock state commits once per retired request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= '0;
			owner_depth_q <= '0;
			for (int i = 0; i < ENTRIES; i++) rd_depth_q[i] <= '0;
		end else if (adv) begin
			st_q          <= st_nxt;
			owner_depth_q <= owner_depth_nxt;
			if (rd_we) rd_depth_q[idx] <= rd_depth_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) rsp_q <= rsp_nxt;
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.must_wait          = rsp_q.must_wait;
	assign rsp.wait_on            = rsp_q.wait_on;
	assign rsp.wake_even_readers  = rsp_q.wake_even_readers;
	assign rsp.wake_odd_readers   = rsp_q.wake_odd_readers;
	assign rsp.wake_writer        = rsp_q.wake_writer;
	assign rsp.clear_even_readers = rsp_q.clear_even_readers;
	assign rsp.clear_odd_readers  = rsp_q.clear_odd_readers;
	assign rsp.success            = rsp_q.success;
	assign rsp.waiting_count      = rsp_q.waiting_count;
	assign rsp.error              = rsp_q.error;
endmodule

/* design/rwl_checker.sv */
// Port-level checks for the reader/writer lock manager, bound to the top level.
// Depends on rwl_pkg and reader_writer_lock_manager_core_assert.svh.
`include "reader_writer_lock_manager_core_assert.svh"

module rwl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       rsp_must_wait,
	input logic [rwl_pkg::ON_W-1:0]   rsp_wait_on,
	input logic                       rsp_wake_even,
	input logic                       rsp_wake_odd,
	input logic                       rsp_wake_writer,
	input logic                       rsp_clear_even,
	input logic                       rsp_clear_odd,
	input logic                       rsp_success,
	input logic [rwl_pkg::WCNT_W-1:0] rsp_waiting_count,
	input logic                       rsp_error
);
	import rwl_pkg::*;

	// a flagged request reports nothing but its error and the count
	`RWL_ASSERT_IMP(a_err_only, clk, arst_n, rsp_valid && rsp_error, !rsp_must_wait && !rsp_wake_even && !rsp_wake_odd && !rsp_wake_writer && !rsp_clear_even && !rsp_clear_odd && !rsp_success)

	`RWL_ASSERT_IMP(a_no_wait_code, clk, arst_n, rsp_valid && !rsp_must_wait, rsp_wait_on == WAIT_EVEN)

	// waking one read phase always clears the other
	`RWL_ASSERT_IMP(a_phase_pair, clk, arst_n, rsp_valid && (rsp_wake_even || rsp_wake_odd), (rsp_wake_even == rsp_clear_odd) && (rsp_wake_odd == rsp_clear_even))

	`RWL_ASSERT_NXT(a_stall_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_waiting_count) && $stable(rsp_error) && $stable(rsp_success) && $stable(rsp_wait_on))
endmodule

bind reader_writer_lock_manager_core rwl_checker u_rwl_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_must_wait    (rsp.must_wait),
	.rsp_wait_on      (rsp.wait_on),
	.rsp_wake_even    (rsp.wake_even_readers),
	.rsp_wake_odd     (rsp.wake_odd_readers),
	.rsp_wake_writer  (rsp.wake_writer),
	.rsp_clear_even   (rsp.clear_even_readers),
	.rsp_clear_odd    (rsp.clear_odd_readers),
	.rsp_success      (rsp.success),
	.rsp_waiting_count(rsp.waiting_count),
	.rsp_error        (rsp.error)
);

/* test/tb_top.sv */
// Self-checking testbench for reader_writer_lock_manager_core.
// Depends on rwl_pkg, rwl_req_if and rwl_rsp_if; keeps its own lock predictor
// and checks every result transfer against it, field by field.
`timescale 1ns / 100ps

module tb_top;
	import rwl_pkg::*;

	localparam int LOCK_THREADS    = 16;
	localparam int LOCK_DEPTH_BITS = 8;
	localparam int THREAD_LAST     = LOCK_THREADS - 1;
	localparam int DEPTH_LIMIT     = (1 << LOCK_DEPTH_BITS) - 1;
	localparam int COUNT_LIMIT     = int'(COUNT_MAX);
	localparam int WAITING_LIMIT   = int'(WCNT_MAX);
	localparam int RANDOM_ITEMS    = 210;

	// mode codes the block must reject
	localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = 3'd5;
	localparam logic [MODE_W-1:0] MODE_LAST_UNUSED  = 3'd7;

	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [TID_W-1:0]  tid;
	} lock_req_t;

	logic clk;
	logic arst_n;

	rwl_req_if req_ch();
	rwl_rsp_if rsp_ch();

	reader_writer_lock_manager_core #(
		.THREADS(LOCK_THREADS),
		.DEPTH_BITS(LOCK_DEPTH_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// pending requests (filled up front) and outcomes still owed by the block
	lock_req_t lock_requests[$];
	rwl_rsp_t  lock_outcomes[$];
	int        mismatches = 0;
	int        pushed_items = 0;

	// predicted lock state, mirrors the block after each accepted request
	bit wr_active = 0;
	int wr_queued = 0;
	int rd_queued = 0;
	int rd_active = 0;
	bit phase_odd = 0;
	bit own_valid = 0;
	int own_tid = 0;
	int own_depth = 0;
	int rd_depth[LOCK_THREADS];

	// handshake bookkeeping between the posedge monitor and negedge drivers
	bit req_taken = 0;
	int send_gap = 0;
	int send_calm = 0;
	int recv_gap = 0;
	int recv_calm = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, and now and then a calm stretch
	// with no idling at all.
	function automatic int idle_cycles(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void push_req(int op, int tid);
		lock_req_t item;
		item.op = MODE_W'(op);
		item.tid = TID_W'(tid);
		lock_requests.push_back(item);
		pushed_items++;
	endfunction

	function automatic void take_ownership(int tid);
		wr_active = 1'b1;
		own_valid = 1'b1;
		own_tid = tid;
		own_depth = 1;
	endfunction

	// Lock predictor: applies one request to the predicted state and returns
	// the outcome the block must report for it. Any rejected request leaves
	// the state untouched and reports only error and the waiting count.
	function automatic rwl_rsp_t resolve_lock_request(logic [MODE_W-1:0] op,
			logic [TID_W-1:0] tid_in);
		rwl_rsp_t r;
		bit fault;
		bit owner;
		bit down;
		int tid;
		int d;
		int waiting;
		r = '0;
		r.success = 1'b1;
		fault = 1'b0;
		tid = int'(tid_in);
		owner = own_valid && own_tid == tid;
		case (op)
			MODE_BEGIN_READ: begin
				d = rd_depth[tid];
				if (d >= DEPTH_LIMIT) begin
					fault = 1'b1;
				end else begin
					// only the first read of a non-owner touches the counters
					if (!owner && d == 0) begin
						if (wr_active) begin
							if (rd_active >= COUNT_LIMIT) begin
								fault = 1'b1;
							end else begin
								rd_active++;
								r.must_wait = 1'b1;
								r.wait_on = phase_odd ? WAIT_ODD : WAIT_EVEN;
							end
						end else if (wr_queued != 0) begin
							// writer preference: queue behind the waiting writer
							if (rd_queued >= COUNT_LIMIT) begin
								fault = 1'b1;
							end else begin
								rd_queued++;
								r.must_wait = 1'b1;
								r.wait_on = phase_odd ? WAIT_ODD : WAIT_EVEN;
							end
						end else if (rd_active >= COUNT_LIMIT) begin
							fault = 1'b1;
						end else begin
							rd_active++;
						end
					end
					if (!fault)
						rd_depth[tid] = d + 1;
				end
			end
			MODE_END_READ: begin
				d = rd_depth[tid];
				if (d == 0) begin
					fault = 1'b1;
				end else begin
					d--;
					rd_depth[tid] = d;
					if (d == 0 && !owner) begin
						if (rd_active == 1 && wr_queued != 0) begin
							// last reader out hands the lock to a queued writer
							wr_queued--;
							wr_active = 1'b1;
							rd_active = rd_queued;
							rd_queued = 0;
							r.wake_writer = 1'b1;
						end else if (rd_active != 0) begin
							rd_active--;
						end
					end
				end
			end
			MODE_BEGIN_WRITE: begin
				if (owner) begin
					if (own_depth >= DEPTH_LIMIT)
						fault = 1'b1;
					else
						own_depth++;
				end else if (rd_depth[tid] != 0) begin
					// upgrade of a held read lock
					if (rd_active > 1) begin
						if (wr_queued >= COUNT_LIMIT) begin
							fault = 1'b1;
						end else begin
							wr_queued++;
							rd_active--;
							r.must_wait = 1'b1;
							r.wait_on = WAIT_WRITE;
						end
					end else if (wr_queued != 0) begin
						wr_active = 1'b1;
						rd_active = rd_queued + (rd_active != 0 ? rd_active - 1 : 0);
						rd_queued = 0;
						r.wake_writer = 1'b1;
						r.must_wait = 1'b1;
						r.wait_on = WAIT_WRITE;
					end else begin
						if (rd_active != 0)
							rd_active--;
						take_ownership(tid);
					end
				end else if (wr_active || rd_active != 0 || wr_queued != 0) begin
					if (wr_queued >= COUNT_LIMIT) begin
						fault = 1'b1;
					end else begin
						wr_queued++;
						r.must_wait = 1'b1;
						r.wait_on = WAIT_WRITE;
					end
				end else begin
					take_ownership(tid);
				end
			end
			MODE_END_WRITE: begin
				if (own_valid && own_tid != tid) begin
					fault = 1'b1;
				end else if (own_valid && own_depth > 1) begin
					own_depth--;
					r.success = 1'b0;
				end else if (!own_valid && !wr_active) begin
					fault = 1'b1;
				end else begin
					// full release; with no owner recorded this is a woken writer
					down = rd_depth[tid] != 0;
					if (down && rd_active >= COUNT_LIMIT) begin
						fault = 1'b1;
					end else begin
						own_valid = 1'b0;
						own_tid = 0;
						own_depth = 0;
						if (phase_odd)
							r.clear_even_readers = 1'b1;
						else
							r.clear_odd_readers = 1'b1;
						if (down || rd_active != 0) begin
							if (down)
								rd_active++;
							wr_active = 1'b0;
							if (phase_odd)
								r.wake_odd_readers = 1'b1;
							else
								r.wake_even_readers = 1'b1;
						end else if (wr_queued != 0) begin
							wr_queued--;
							r.wake_writer = 1'b1;
						end else begin
							wr_active = 1'b0;
						end
						phase_odd = !phase_odd;
					end
				end
			end
			MODE_TRY_WRITE: begin
				if (owner) begin
					if (own_depth >= DEPTH_LIMIT)
						fault = 1'b1;
					else
						own_depth++;
				end else if (rd_depth[tid] != 0) begin
					if (rd_active > 1 || wr_queued != 0) begin
						r.success = 1'b0;
					end else begin
						if (rd_active != 0)
							rd_active--;
						take_ownership(tid);
					end
				end else if (wr_active || rd_active != 0 || wr_queued != 0) begin
					r.success = 1'b0;
				end else begin
					take_ownership(tid);
				end
			end
			default: fault = 1'b1;
		endcase
		if (fault) begin
			r = '0;
			r.error = 1'b1;
		end
		waiting = rd_queued + wr_queued + (wr_active ? rd_active : 0);
		if (waiting > WAITING_LIMIT)
			waiting = WAITING_LIMIT;
		r.waiting_count = waiting[WCNT_W-1:0];
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endfunction

	// Monitor: samples both channels at the rising edge. A request transfer
	// runs the predictor; a result transfer is checked against the oldest
	// outstanding outcome.
	always @(posedge clk) begin
		rwl_rsp_t want;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			lock_outcomes.push_back(resolve_lock_request(req_ch.mode, req_ch.thread_id));
			req_taken = 1'b1;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (lock_outcomes.size() == 0) begin
				$display("%0t: result transfer with no outcome outstanding", $time);
				mismatches++;
			end else begin
				want = lock_outcomes.pop_front();
				check_field("must_wait", want.must_wait, rsp_ch.must_wait);
				check_field("wait_on", want.wait_on, rsp_ch.wait_on);
				check_field("wake_even_readers", want.wake_even_readers,
					rsp_ch.wake_even_readers);
				check_field("wake_odd_readers", want.wake_odd_readers, rsp_ch.wake_odd_readers);
				check_field("wake_writer", want.wake_writer, rsp_ch.wake_writer);
				check_field("clear_even_readers", want.clear_even_readers,
					rsp_ch.clear_even_readers);
				check_field("clear_odd_readers", want.clear_odd_readers,
					rsp_ch.clear_odd_readers);
				check_field("success", want.success, rsp_ch.success);
				check_field("waiting_count", want.waiting_count, rsp_ch.waiting_count);
				check_field("error", want.error, rsp_ch.error);
			end
		end
	end

	// Request driver: updates at the falling edge. A held request stays put
	// until its transfer; then an idle gap may follow before the next one.
	always @(negedge clk) begin
		lock_req_t item;
		if (arst_n && (!req_ch.valid || req_taken)) begin
			req_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (lock_requests.size() != 0) begin
				item = lock_requests.pop_front();
				req_ch.mode <= item.op;
				req_ch.thread_id <= item.tid;
				req_ch.valid <= 1'b1;
				send_gap = idle_cycles(send_calm);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure, independent of whether a result is waiting.
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				recv_gap = idle_cycles(recv_calm);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int t;
		int u;
		int n;
		int k;
		int base;
		foreach (rd_depth[i])
			rd_depth[i] = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_BEGIN_READ;
		req_ch.thread_id = '0;
		rsp_ch.ready = 1'b0;

		// Depth limit, run from the clean reset state: write recursion up to
		// the top and one past it, then unwound again.
		push_req(MODE_TRY_WRITE, 13);
		repeat (DEPTH_LIMIT)
			push_req(MODE_BEGIN_WRITE, 13);
		repeat (DEPTH_LIMIT)
			push_req(MODE_END_WRITE, 13);

		// Directed walk through every operation and the corner cases.
		push_req(MODE_BEGIN_READ, 0);
		push_req(MODE_BEGIN_READ, 0);       // recursive read
		push_req(MODE_BEGIN_READ, 15);
		push_req(MODE_BEGIN_WRITE, 0);      // upgrade with other readers: queues
		push_req(MODE_BEGIN_READ, 5);       // writer waiting: reader queued
		push_req(MODE_TRY_WRITE, 7);        // fails while busy
		push_req(MODE_END_READ, 15);        // last reader hands over to writer
		push_req(MODE_END_WRITE, 0);        // woken writer, no owner, downgrades
		push_req(MODE_END_READ, 0);
		push_req(MODE_END_READ, 0);
		push_req(MODE_END_READ, 0);         // unmatched read release
		push_req(MODE_END_READ, 5);
		push_req(MODE_END_WRITE, 3);        // no writer at all
		push_req(MODE_TRY_WRITE, 9);        // free lock: acquired
		push_req(MODE_BEGIN_WRITE, 9);
		push_req(MODE_END_WRITE, 4);        // not the owner
		push_req(MODE_END_WRITE, 9);        // partial release
		push_req(MODE_END_WRITE, 9);
		push_req(MODE_FIRST_UNUSED, 10);
		push_req(MODE_FIRST_UNUSED + 1, 6);
		push_req(MODE_LAST_UNUSED, 15);
		push_req(MODE_BEGIN_READ, 1);
		push_req(MODE_BEGIN_WRITE, 2);      // queued behind reader 1
		push_req(MODE_BEGIN_WRITE, 1);      // lone reader wakes the queued writer and waits
		push_req(MODE_END_READ, 1);         // active reader count already zero
		push_req(MODE_END_WRITE, 2);

		// Random part: mostly well-formed lock sessions with random threads and
		// depths, mixed with bursts that drive the counters to their limits,
		// broken releases and plain noise.
		base = pushed_items;
		while (pushed_items - base < RANDOM_ITEMS) begin
			t = $urandom_range(0, THREAD_LAST);
			u = $urandom_range(0, THREAD_LAST);
			n = $urandom_range(1, 4);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat (n)
						push_req(MODE_BEGIN_READ, t);
					if ($urandom_range(0, 3) == 0) begin
						push_req($urandom_range(0, 1) ? MODE_BEGIN_WRITE : MODE_TRY_WRITE, t);
						push_req(MODE_END_WRITE, t);
					end
					repeat (n)
						push_req(MODE_END_READ, t);
				end
				3, 4: begin
					push_req($urandom_range(0, 1) ? MODE_BEGIN_WRITE : MODE_TRY_WRITE, t);
					repeat (n - 1)
						push_req(MODE_BEGIN_WRITE, t);
					if ($urandom_range(0, 1)) begin
						push_req(MODE_BEGIN_READ, t);
						push_req(MODE_END_WRITE, t);
						push_req(MODE_END_READ, t);
					end
					repeat (n)
						push_req(MODE_END_WRITE, t);
				end
				5: begin
					push_req(MODE_BEGIN_READ, t);
					push_req(MODE_BEGIN_WRITE, u);
					push_req(MODE_BEGIN_READ, $urandom_range(0, THREAD_LAST));
					push_req(MODE_END_READ, t);
					push_req(MODE_END_WRITE, u);
				end
				6: begin
					repeat (2 * n)
						push_req($urandom_range(0, MODE_LAST_UNUSED),
							$urandom_range(0, THREAD_LAST));
				end
				7: begin
					// pile up waiting writers toward the queue limit
					k = $urandom_range(20, 40);
					repeat (k)
						push_req(MODE_BEGIN_WRITE, $urandom_range(0, THREAD_LAST));
					repeat (k)
						push_req(MODE_END_WRITE, $urandom_range(0, THREAD_LAST));
				end
				8: begin
					// read churn behind a waiting writer inflates the reader queue
					push_req(MODE_BEGIN_READ, u);
					push_req(MODE_BEGIN_WRITE, t);
					k = $urandom_range(20, 40);
					repeat (k) begin
						push_req(MODE_BEGIN_READ, t ^ 1);
						push_req(MODE_END_READ, t ^ 1);
					end
					push_req(MODE_END_READ, u);
				end
				default: begin
					repeat (n)
						push_req($urandom_range(0, 1) ? MODE_END_READ : MODE_END_WRITE,
							$urandom_range(0, THREAD_LAST));
				end
			endcase
		end

		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: every request sent and every outcome delivered
		while (lock_requests.size() != 0 || req_ch.valid || lock_outcomes.size() != 0)
			@(negedge clk);
		// keep clocking to catch any stray result
		repeat (8)
			@(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
